// ----- rtl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/mfps_pkg.sv -----
package mfps_pkg;

  // default screen geometry
  localparam int DEF_WIDTH  = 256;
  localparam int DEF_HEIGHT = 128;

  // width of the coordinate fields
  localparam int FIELD_W = 9;

  // number of address commands ahead of the data
  localparam int CMD_COUNT = 4;

  // command codes on kind
  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_FILL  = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_READ,
    ST_WRITE,
    ST_FLUSH,
    ST_FLUSH_DATA
  } state_t;

  // lcd address commands sent at the head of a flush
  function automatic logic [7:0] addr_cmd(input logic [1:0] idx);
    logic [7:0] code;
    case (idx)
      2'd0:    code = 8'h70;
      2'd1:    code = 8'h60;
      2'd2:    code = 8'h10;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/mono_framebuffer_page_scan.sv -----
// Monochrome frame store in LCD page layout with a byte-serial flush port.
// Command channel: pulse start with kind and its fields while busy is low;
// the word is taken at that clock edge and busy rises for the work.
// kind pixel writes one bit, kind fill writes every on-screen pixel of
// an inclusive box, kind flush returns the next LCD byte.
// Work from accept until busy falls:
//   pixel write     setup, read, write of one store byte
//   box fill        setup, then a read and a write for each store byte the
//                   box touches (separate read and write ports, one byte a pass)
//   flush command   flush state; valid in the next cycle, as busy falls
//   flush data      store read, then output; valid as busy falls
// One result word per flush step appears on out_byte/is_data/last for one
// cycle marked by valid; the receiver cannot stall, so the word must be
// taken in that cycle. After reset the store is cleared one byte a cycle,
// all SCREEN_WIDTH * ceil(SCREEN_HEIGHT / 8) bytes, with busy high; the
// flush position returns to the first address command.
`include "assert_macros.svh"

module mono_framebuffer_page_scan #(
  parameter int SCREEN_WIDTH  = mfps_pkg::DEF_WIDTH,
  parameter int SCREEN_HEIGHT = mfps_pkg::DEF_HEIGHT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] kind,
  input  logic [8:0] x_start,
  input  logic [8:0] y_start,
  input  logic [8:0] x_end,
  input  logic [8:0] y_end,
  input  logic       pixel_on,
  output logic       busy,
  output logic       valid,
  output logic [7:0] out_byte,
  output logic       is_data,
  output logic       last
);
  import mfps_pkg::*;

  localparam int PAGES       = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int CW          = $clog2(SCREEN_WIDTH);
  localparam int PW          = (PAGES > 1) ? $clog2(PAGES) : 1;

  localparam logic [FIELD_W-1:0] XMAX      = FIELD_W'(SCREEN_WIDTH - 1);
  localparam logic [FIELD_W-1:0] YMAX      = FIELD_W'(SCREEN_HEIGHT - 1);
  localparam logic [FIELD_W:0]   XLIM      = (FIELD_W + 1)'(SCREEN_WIDTH);
  localparam logic [FIELD_W:0]   YLIM      = (FIELD_W + 1)'(SCREEN_HEIGHT);
  localparam logic [CW-1:0]      LAST_COL  = CW'(SCREEN_WIDTH - 1);
  localparam logic [PW-1:0]      LAST_PAGE = PW'(PAGES - 1);
  localparam logic [AW-1:0]      LAST_ADDR = AW'(STORE_BYTES - 1);
  localparam logic [AW-1:0]      PAGE_STEP = AW'(PAGES);
  localparam logic [1:0]         LAST_CMD  = 2'(CMD_COUNT - 1);

  state_t state, state_next;

  // frame store
  logic [7:0]    store [STORE_BYTES];
  logic [7:0]    rd_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  // clearing pass
  logic [AW-1:0] clr_addr;

  // fill walker
  logic [FIELD_W-1:0] xs_r, ys_r, xe_r, ye_r;
  logic               on_r;
  logic [CW-1:0]      x_cur;
  logic [PW-1:0]      pg;
  logic [AW-1:0]      col_base;

  // flush position
  logic          flush_in_data;
  logic [1:0]    flush_cmd;
  logic [CW-1:0] fcol;
  logic [PW-1:0] fpage;
  logic [AW-1:0] faddr;

  logic [FIELD_W-1:0] xe_clip, ye_clip;
  logic               setup_empty;
  logic [PW-1:0]      ys_page, ye_page;
  logic [AW-1:0]      fill_addr;
  logic [2:0]         bit_lo, bit_hi;
  logic [7:0]         mask;
  logic               fill_done;
  logic               flush_last;

  // terms for the checks
  logic               word_out;
  logic               draw_cmd;
  logic               fill_busy;

  assign busy = (state != ST_IDLE);

  // box clipping to the screen
  assign xe_clip     = ({1'b0, xe_r} >= XLIM) ? XMAX : xe_r;
  assign ye_clip     = ({1'b0, ye_r} >= YLIM) ? YMAX : ye_r;
  assign setup_empty = (xs_r > xe_clip) || (ys_r > ye_clip);

  // current byte of the box and the rows it covers
  assign ys_page   = ys_r[PW+2:3];
  assign ye_page   = ye_r[PW+2:3];
  assign fill_addr = col_base + AW'(pg);
  assign bit_lo    = (pg == ys_page) ? ys_r[2:0] : 3'd0;
  assign bit_hi    = (pg == ye_page) ? ye_r[2:0] : 3'd7;
  assign mask      = (8'hFF << bit_lo) & (8'hFF >> (3'd7 - bit_hi));
  assign fill_done = (pg == ye_page) && (x_cur == xe_r[CW-1:0]);

  assign flush_last = (fcol == LAST_COL) && (fpage == LAST_PAGE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and store port control
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = fill_addr;
    mem_wdata  = on_r ? (rd_data | mask) : (rd_data & ~mask);
    rd_en      = 1'b0;
    rd_addr    = fill_addr;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = 8'h00;
        if (clr_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          unique case (kind) inside
            KIND_PIXEL, KIND_FILL: state_next = ST_SETUP;
            KIND_FLUSH:            state_next = ST_FLUSH;
            default:               state_next = ST_IDLE;
          endcase
        end
      end
      ST_SETUP: begin
        state_next = setup_empty ? ST_IDLE : ST_READ;
      end
      ST_READ: begin
        rd_en      = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        mem_we     = 1'b1;
        state_next = fill_done ? ST_IDLE : ST_READ;
      end
      ST_FLUSH: begin
        if (flush_in_data) begin
          rd_en      = 1'b1;
          rd_addr    = faddr;
          state_next = ST_FLUSH_DATA;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH_DATA: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // store memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr      <= '0;
      flush_in_data <= 1'b0;
      flush_cmd     <= '0;
      fcol          <= '0;
      fpage         <= '0;
      faddr         <= '0;
      valid         <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
        end
        ST_IDLE: begin
          // capture the command word; a pixel is a one-pixel box
          if (start) begin
            xs_r <= x_start;
            ys_r <= y_start;
            xe_r <= (kind == KIND_PIXEL) ? x_start : x_end;
            ye_r <= (kind == KIND_PIXEL) ? y_start : y_end;
            on_r <= pixel_on;
          end
        end
        ST_SETUP: begin
          xe_r     <= xe_clip;
          ye_r     <= ye_clip;
          x_cur    <= CW'(xs_r);
          pg       <= ys_page;
          col_base <= AW'(xs_r) * PAGE_STEP;
        end
        ST_WRITE: begin
          // pages inside a column, then the next column
          if (pg == ye_page) begin
            pg       <= ys_page;
            x_cur    <= x_cur + 1'b1;
            col_base <= col_base + PAGE_STEP;
          end else begin
            pg <= pg + 1'b1;
          end
        end
        ST_FLUSH: begin
          if (!flush_in_data) begin
            out_byte  <= addr_cmd(flush_cmd);
            is_data   <= 1'b0;
            last      <= 1'b0;
            valid     <= 1'b1;
            flush_cmd <= flush_cmd + 1'b1;
            if (flush_cmd == LAST_CMD) begin
              flush_in_data <= 1'b1;
            end
          end
        end
        ST_FLUSH_DATA: begin
          out_byte <= rd_data;
          is_data  <= 1'b1;
          last     <= flush_last;
          valid    <= 1'b1;
          // walk columns within a page, then the next page
          if (flush_last) begin
            flush_in_data <= 1'b0;
            fcol          <= '0;
            fpage         <= '0;
            faddr         <= '0;
          end else if (fcol == LAST_COL) begin
            fcol  <= '0;
            fpage <= fpage + 1'b1;
            faddr <= AW'(fpage) + 1'b1;
          end else begin
            fcol  <= fcol + 1'b1;
            faddr <= faddr + PAGE_STEP;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // states that send a word, accepted draw commands, fill walk in progress
  assign word_out  = (state == ST_FLUSH && !flush_in_data) || (state == ST_FLUSH_DATA);
  assign draw_cmd  = start && !busy && (kind == KIND_PIXEL || kind == KIND_FILL);
  assign fill_busy = (state == ST_READ) || (state == ST_WRITE);

  // checks
  `ASSERT_NXT(a_valid_src, clk, rst, !word_out, !valid)
  `ASSERT_IMP(a_last_data, clk, rst, valid && last, is_data)
  `ASSERT_NXT(a_draw_setup, clk, rst, draw_cmd, state == ST_SETUP)
  `ASSERT_IMP(a_fill_bound, clk, rst, fill_busy, x_cur <= xe_r[CW-1:0] && pg <= ye_page)

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mfps_pkg::*;

  localparam int SCR_W       = DEF_WIDTH;
  localparam int SCR_H       = DEF_HEIGHT;
  localparam int PAGES       = (SCR_H + 7) / 8;
  localparam int STORE_BYTES = SCR_W * PAGES;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 16;
  localparam int RAND_PER_PHASE = 232;

  // kind code that the block leaves alone
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // address commands at the head of every scan, first one in the top byte
  localparam logic [31:0] ADDR_CMD_SEQ = 32'h70_60_10_00;

  typedef struct packed {
    logic [1:0] kind;
    logic [8:0] xs;
    logic [8:0] ys;
    logic [8:0] xe;
    logic [8:0] ye;
    logic       on;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_data;
    logic       last;
  } lcd_word_t;

  typedef struct packed {
    cmd_t      c;
    logic      typed;
    lcd_word_t w;
  } row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       start;
  logic [1:0] kind;
  logic [8:0] x_start;
  logic [8:0] y_start;
  logic [8:0] x_end;
  logic [8:0] y_end;
  logic       pixel_on;
  logic       busy;
  logic       valid;
  logic [7:0] out_byte;
  logic       is_data;
  logic       last;

  // predictor state: frame image and scan position
  logic [7:0] frame_img [STORE_BYTES];
  int         scan_pos;

  lcd_word_t  lcd_expect_q [$];
  int         error_count;
  int         cycle_count;
  int         idle_pct;

  mono_framebuffer_page_scan #(
    .SCREEN_WIDTH  (SCR_W),
    .SCREEN_HEIGHT (SCR_H)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .kind     (kind),
    .x_start  (x_start),
    .y_start  (y_start),
    .x_end    (x_end),
    .y_end    (y_end),
    .pixel_on (pixel_on),
    .busy     (busy),
    .valid    (valid),
    .out_byte (out_byte),
    .is_data  (is_data),
    .last     (last)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 40) begin
      $display("error at %0t: %s", $time, msg);
    end
  endtask

  task automatic plot_pixel(input int x, input int y, input logic on);
    int idx;
    if (x < SCR_W && y < SCR_H) begin
      idx = x * PAGES + y / 8;
      frame_img[idx][y % 8] = on;
    end
  endtask

  // update the image for one command word, give the lcd word it returns
  task automatic apply_cmd(input cmd_t c, output logic has_w, output lcd_word_t w);
    int xe;
    int ye;
    int k;
    int addr;
    has_w = 1'b0;
    w = '0;
    case (c.kind)
      KIND_PIXEL: plot_pixel(c.xs, c.ys, c.on);
      KIND_FILL: begin
        // clip to the screen; an empty box runs no loop
        xe = (c.xe >= SCR_W) ? SCR_W - 1 : c.xe;
        ye = (c.ye >= SCR_H) ? SCR_H - 1 : c.ye;
        for (int y = c.ys; y <= ye; y++) begin
          for (int x = c.xs; x <= xe; x++) begin
            plot_pixel(x, y, c.on);
          end
        end
      end
      KIND_FLUSH: begin
        has_w = 1'b1;
        if (scan_pos < CMD_COUNT) begin
          w.data_byte = ADDR_CMD_SEQ[31 - 8 * scan_pos -: 8];
          scan_pos++;
        end else begin
          // data goes out page by page, column by column within a page
          k = scan_pos - CMD_COUNT;
          addr = (k % SCR_W) * PAGES + k / SCR_W;
          w.data_byte = frame_img[addr];
          w.is_data = 1'b1;
          w.last = (k + 1 >= STORE_BYTES);
          scan_pos = w.last ? 0 : scan_pos + 1;
        end
      end
      default: ;
    endcase
  endtask

  // mostly on screen, some at the border, some anywhere in the field
  function automatic logic [8:0] pick_coord(input int span);
    int r;
    r = $urandom_range(99);
    if (r < 10) begin
      return 9'($urandom_range(511));
    end else if (r < 20) begin
      return 9'(span - 1 + $urandom_range(1));
    end
    return 9'($urandom_range(span - 1));
  endfunction

  function automatic cmd_t random_cmd(input logic mostly_flush);
    cmd_t c;
    int r;
    c.xs = pick_coord(SCR_W);
    c.ys = pick_coord(SCR_H);
    c.xe = c.xs + 9'($urandom_range(15));
    c.ye = c.ys + 9'($urandom_range(15));
    c.on = 1'($urandom_range(1));
    r = $urandom_range(199);
    if (r == 0) begin
      // rare box over most of the screen
      c.xs = 9'($urandom_range(31));
      c.ys = 9'($urandom_range(31));
      c.xe = 9'($urandom_range(511));
      c.ye = 9'($urandom_range(511));
    end else if (r < 20) begin
      // corners swapped, mostly an empty box
      c.xs = c.xe;
      c.xe = c.xs - 9'($urandom_range(15));
    end else if (r < 35) begin
      c.ys = c.ye;
      c.ye = c.ys - 9'($urandom_range(15));
    end
    r = $urandom_range(99);
    if (r < (mostly_flush ? 85 : 35)) begin
      c.kind = KIND_FLUSH;
    end else begin
      r = $urandom_range(19);
      c.kind = (r == 0) ? KIND_UNUSED : (r < 10) ? KIND_PIXEL : KIND_FILL;
    end
    return c;
  endfunction

  function automatic row_t mk_row(input logic [1:0] k, input int xs, input int ys,
                                  input int xe, input int ye, input logic on,
                                  input logic typed, input logic [7:0] b,
                                  input logic d, input logic l);
    row_t r;
    r.c = {k, 9'(xs), 9'(ys), 9'(xe), 9'(ye), on};
    r.typed = typed;
    r.w = {b, d, l};
    return r;
  endfunction

  // hand one command word over, with a random gap first
  task automatic send_cmd(input cmd_t c, input logic typed, input lcd_word_t typed_w);
    logic      has_w;
    lcd_word_t w;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start    <= 1'b1;
    kind     <= c.kind;
    x_start  <= c.xs;
    y_start  <= c.ys;
    x_end    <= c.xe;
    y_end    <= c.ye;
    pixel_on <= c.on;
    do @(posedge clk); while (busy);
    apply_cmd(c, has_w, w);
    if (has_w) begin
      lcd_expect_q.push_back(typed ? typed_w : w);
    end
  endtask

  // hold off until every expected word has come back
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (lcd_expect_q.size() != 0) @(posedge clk);
  endtask

  // compare each returned word with the oldest expectation
  always @(posedge clk) begin : check_words
    lcd_word_t want;
    if (!rst && valid) begin
      if (lcd_expect_q.size() == 0) begin
        flag_error($sformatf("word %h/%b/%b with nothing expected",
                             out_byte, is_data, last));
      end else begin
        want = lcd_expect_q.pop_front();
        if (out_byte !== want.data_byte) begin
          flag_error($sformatf("out_byte %h, expected %h", out_byte, want.data_byte));
        end
        if (is_data !== want.is_data) begin
          flag_error($sformatf("is_data %b, expected %b", is_data, want.is_data));
        end
        if (last !== want.last) begin
          flag_error($sformatf("last %b, expected %b", last, want.last));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    row_t plan [$];
    rst         = 1'b1;
    start       = 1'b0;
    kind        = KIND_PIXEL;
    x_start     = '0;
    y_start     = '0;
    x_end       = '0;
    y_end       = '0;
    pixel_on    = 1'b0;
    error_count = 0;
    cycle_count = 0;
    idle_pct    = 0;
    scan_pos    = 0;
    foreach (frame_img[i]) frame_img[i] = '0;

    // directed: address commands, screen corners, off-screen writes, empty
    // and clipped boxes, unused kind, full-screen set and clear
    plan.push_back(mk_row(KIND_FLUSH,    0,   0,   0,   0, 1'b0, 1'b1, 8'h70, 1'b0, 1'b0));
    plan.push_back(mk_row(KIND_PIXEL,    0,   0,   0,   0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
    plan.push_back(mk_row(KIND_FLUSH,  511, 511, 511, 511, 1'b1, 1'b1, 8'h60, 1'b0, 1'b0));
    plan.push_back(mk_row(KIND_PIXEL,  255, 127,   0,   0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
    plan.push_back(mk_row(KIND_PIXEL,  256,   0,   0,   0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
    plan.push_back(mk_row(KIND_PIXEL,    0, 128,   0,   0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
    plan.push_back(mk_row(KIND_PIXEL,  511, 511, 511, 511, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
    plan.push_back(mk_row(KIND_FLUSH,    0,   0,   0,   0, 1'b0, 1'b1, 8'h10, 1'b0, 1'b0));
    plan.push_back(mk_row(KIND_FLUSH,    0,   0,   0,   0, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0));
    plan.push_back(mk_row(KIND_FLUSH,    0,   0,   0,   0, 1'b0, 1'b1, 8'h01, 1'b1, 1'b0));
    plan.push_back(mk_row(KIND_FILL,    10,   0,   9,   7, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
    plan.push_back(mk_row(KIND_FILL,     0,   8,   7,   7, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
    plan.push_back(mk_row(KIND_FILL,     1,   0,   1,   7, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
    plan.push_back(mk_row(KIND_FLUSH,    0,   0,   0,   0, 1'b0, 1'b1, 8'hff, 1'b1, 1'b0));
    plan.push_back(mk_row(KIND_UNUSED,   2,   0,   2,   7, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
    plan.push_back(mk_row(KIND_FILL,   250, 120, 511, 511, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
    plan.push_back(mk_row(KIND_PIXEL,    2,   3,   0,   0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
    plan.push_back(mk_row(KIND_FILL,     2,   5,   2,   5, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
    plan.push_back(mk_row(KIND_FLUSH,    0,   0,   0,   0, 1'b0, 1'b1, 8'h08, 1'b1, 1'b0));
    plan.push_back(mk_row(KIND_FILL,     0,   0, 511, 511, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
    plan.push_back(mk_row(KIND_FLUSH,    0,   0,   0,   0, 1'b0, 1'b1, 8'hff, 1'b1, 1'b0));
    plan.push_back(mk_row(KIND_FILL,     0,   0, 255, 127, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
    plan.push_back(mk_row(KIND_FLUSH,    0,   0,   0,   0, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0));
    plan.push_back(mk_row(KIND_PIXEL,  511,   0,   0,   0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));

    // reset, then the block clears its store with busy high
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      send_cmd(plan[i].c, plan[i].typed, plan[i].w);
    end

    // phases of sender idling: none, heavy, light, none; the receiver
    // cannot stall, so only the sender side varies
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      idle_pct = (ph == 1) ? 80 : (ph == 2) ? 22 : 0;
      repeat (RAND_PER_PHASE) begin
        if ($urandom_range(49) == 0) begin
          settle();
        end
        send_cmd(random_cmd(1'b0), 1'b0, '0);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (lcd_expect_q.size() != 0) begin
      flag_error($sformatf("%0d words never came", lcd_expect_q.size()));
    end
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
